[src/preemptive_priority_scheduler_assert.svh]
// assertion helpers shared by the rtl
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pps assertion failed");

// next-cycle implication
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pps assertion failed");

`endif

[src/pps_pkg.sv]
package pps_pkg;

  localparam int unsigned HeapDepthDef = 64;
  localparam int unsigned TimeW = 40;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] arrival;
    logic [31:0] remaining;
    logic [31:0] priority_val;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RETIRE,
    ST_DN_X,
    ST_DN_CHK,
    ST_DN_L,
    ST_DN_R,
    ST_DN_W,
    ST_DN_DONE,
    ST_UP_CHK,
    ST_UP,
    ST_OVF,
    ST_FIN
  } state_e;

  // higher priority first, earlier arrival wins ties
  function automatic logic ranks_above(job_t x, job_t y);
    logic r;
    if (x.priority_val != y.priority_val) begin
      r = x.priority_val > y.priority_val;
    end else begin
      r = x.arrival < y.arrival;
    end
    return r;
  endfunction

endpackage

[src/preemptive_priority_scheduler.sv]
// Preemptive priority scheduler. Each input item is either a job arrival
// (kind 0) or a flush (kind 1). Jobs wait in a binary max-heap held in a
// single-port-write, registered-read memory of HEAP_DEPTH entries, ordered
// by priority with the earlier arrival winning ties; the root is the running
// job. On an arrival every job that finishes by the arrival time is retired
// and reported with its finish time, then the new job is inserted and may
// preempt the runner. A flush retires all jobs. An arrival into a full heap
// yields one item with overflow set. The last result of an input carries
// last. One item is handled at a time and in_ready_o is high only in
// idle. A small sequencer walks the heap through the one memory port: an
// insert climbs the heap one level at a time and a retirement sinks it one
// level at a time. Output back-pressure stalls the sequencer only when a
// result is ready.
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH = HeapDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [31:0]         job_id_i,
  input  logic [31:0]         arrival_time_i,
  input  logic [31:0]         run_time_i,
  input  logic [31:0]         priority_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         done_id_o,
  output logic [TimeW-1:0]    finish_time_o,
  output logic                last_o,
  output logic                overflow_o
);

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);

  `include "preemptive_priority_scheduler_assert.svh"

  // heap storage, no reset: entries at or above the count are never read
  job_t mem_q [HEAP_DEPTH];
  job_t rd_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  job_t          mem_wdata;
  logic [AW-1:0] mem_raddr;

  // sequencer state
  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [TimeW-1:0] cur_q, cur_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [AW-1:0]   bidx_q, bidx_d;
  job_t            cand_q, cand_d;
  job_t            x_q, x_d;
  job_t            nj_q, nj_d;
  logic            flush_q, flush_d;
  job_t            root_q;

  // retired result held back until we know whether it is the last one
  logic             pend_v_q, pend_v_d;
  logic [31:0]      pend_id_q, pend_id_d;
  logic [TimeW-1:0] pend_time_q, pend_time_d;

  // output register
  logic             out_v_q;
  logic [31:0]      out_id_q;
  logic [TimeW-1:0] out_time_q;
  logic             out_last_q, out_ovf_q;

  logic             push;
  logic [31:0]      push_id;
  logic [TimeW-1:0] push_time;
  logic             push_last, push_ovf;
  logic             slot_free;

  // shared arithmetic
  logic [TimeW:0]   fin_sum;
  logic [TimeW-1:0] elapsed;
  logic [AW:0]      lchild, rchild, cnt_ext;
  logic [AW-1:0]    parent;

  assign slot_free = !out_v_q || out_ready_i;
  assign fin_sum   = {1'b0, cur_q} + {{(TimeW - 31){1'b0}}, root_q.remaining};
  assign elapsed   = {{(TimeW - 32){1'b0}}, nj_q.arrival} - cur_q;
  assign lchild    = {idx_q, 1'b1};
  assign rchild    = lchild + 1'b1;
  assign cnt_ext   = (AW + 1)'(cnt_q);
  assign parent    = (idx_q - 1'b1) >> 1;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    bidx_d      = bidx_q;
    cand_d      = cand_q;
    x_d         = x_q;
    nj_d        = nj_q;
    flush_d     = flush_q;
    pend_v_d    = pend_v_q;
    pend_id_d   = pend_id_q;
    pend_time_d = pend_time_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = nj_q;
    mem_raddr   = '0;
    push        = 1'b0;
    push_id     = pend_id_q;
    push_time   = pend_time_q;
    push_last   = 1'b0;
    push_ovf    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          nj_d.id           = job_id_i;
          nj_d.arrival      = arrival_time_i;
          nj_d.remaining    = run_time_i;
          nj_d.priority_val = priority_req_i;
          flush_d           = kind_i;
          state_d           = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (flush_q) begin
          state_d = (cnt_q != '0) ? ST_RETIRE : ST_FIN;
        end else if (cnt_q != '0 &&
                     fin_sum <= {{(TimeW - 31){1'b0}}, nj_q.arrival}) begin
          state_d = ST_RETIRE;
        end else if (cnt_q == CW'(HEAP_DEPTH)) begin
          state_d = ST_OVF;
        end else begin
          if (cnt_q == '0) begin
            cur_d = {{(TimeW - 32){1'b0}}, nj_q.arrival};
          end else if (ranks_above(nj_q, root_q) &&
                       {{(TimeW - 32){1'b0}}, nj_q.arrival} > cur_q) begin
            // preempt: charge the runner for the time it has run
            mem_we              = 1'b1;
            mem_waddr           = '0;
            mem_wdata           = root_q;
            mem_wdata.remaining = root_q.remaining - elapsed[31:0];
            cur_d               = {{(TimeW - 32){1'b0}}, nj_q.arrival};
          end
          idx_d   = cnt_q[AW-1:0];
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_UP_CHK;
        end
      end

      ST_RETIRE: begin
        if (!pend_v_q || slot_free) begin
          push        = pend_v_q;
          pend_v_d    = 1'b1;
          pend_id_d   = root_q.id;
          pend_time_d = fin_sum[TimeW-1:0];
          cur_d       = fin_sum[TimeW-1:0];
          cnt_d       = cnt_q - 1'b1;
          mem_raddr   = cnt_d[AW-1:0];
          state_d     = (cnt_d != '0) ? ST_DN_X : ST_CHECK;
        end
      end

      ST_DN_X: begin
        x_d     = rd_q;
        idx_d   = '0;
        state_d = ST_DN_CHK;
      end

      ST_DN_CHK: begin
        if (lchild < cnt_ext) begin
          mem_raddr = lchild[AW-1:0];
          state_d   = ST_DN_L;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_q;
          mem_wdata = x_q;
          state_d   = ST_DN_DONE;
        end
      end

      ST_DN_L: begin
        if (ranks_above(rd_q, x_q)) begin
          cand_d = rd_q;
          bidx_d = lchild[AW-1:0];
        end else begin
          cand_d = x_q;
          bidx_d = idx_q;
        end
        if (rchild < cnt_ext) begin
          mem_raddr = rchild[AW-1:0];
          state_d   = ST_DN_R;
        end else begin
          state_d = ST_DN_W;
        end
      end

      ST_DN_R: begin
        if (ranks_above(rd_q, cand_q)) begin
          cand_d = rd_q;
          bidx_d = rchild[AW-1:0];
        end
        state_d = ST_DN_W;
      end

      ST_DN_W: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        if (bidx_q == idx_q) begin
          mem_wdata = x_q;
          state_d   = ST_DN_DONE;
        end else begin
          mem_wdata = cand_q;
          idx_d     = bidx_q;
          state_d   = ST_DN_CHK;
        end
      end

      ST_DN_DONE: begin
        // idle cpu jumps forward to the next job's arrival
        if ({{(TimeW - 32){1'b0}}, root_q.arrival} > cur_q) begin
          cur_d = {{(TimeW - 32){1'b0}}, root_q.arrival};
        end
        state_d = ST_CHECK;
      end

      ST_UP_CHK: begin
        if (idx_q == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = nj_q;
          state_d   = ST_FIN;
        end else begin
          mem_raddr = parent;
          state_d   = ST_UP;
        end
      end

      ST_UP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        if (ranks_above(nj_q, rd_q)) begin
          mem_wdata = rd_q;
          idx_d     = parent;
          state_d   = ST_UP_CHK;
        end else begin
          mem_wdata = nj_q;
          state_d   = ST_FIN;
        end
      end

      ST_OVF: begin
        if (slot_free) begin
          push = 1'b1;
          if (pend_v_q) begin
            pend_v_d = 1'b0;
          end else begin
            push_id   = '0;
            push_time = '0;
            push_last = 1'b1;
            push_ovf  = 1'b1;
            state_d   = ST_IDLE;
          end
        end
      end

      ST_FIN: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (slot_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          pend_v_d  = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // heap memory and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  // root mirror keeps the running job at hand
  always_ff @(posedge clk_i) begin
    if (mem_we && mem_waddr == '0) begin
      root_q <= mem_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    bidx_q      <= bidx_d;
    cand_q      <= cand_d;
    x_q         <= x_d;
    nj_q        <= nj_d;
    flush_q     <= flush_d;
    pend_id_q   <= pend_id_d;
    pend_time_q <= pend_time_d;
    if (push) begin
      out_id_q   <= push_id;
      out_time_q <= push_time;
      out_last_q <= push_last;
      out_ovf_q  <= push_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      cur_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      cur_q    <= cur_d;
      pend_v_q <= pend_v_d;
      if (push) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_v_q;
  assign done_id_o     = out_id_q;
  assign finish_time_o = out_time_q;
  assign last_o        = out_last_q;
  assign overflow_o    = out_ovf_q;

  `PPS_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(HEAP_DEPTH))
  `PPS_ASSERT_NOW(a_idle_no_pend, clk_i, rst_ni, state_q == ST_IDLE, !pend_v_q)
  `PPS_ASSERT_NOW(a_ovf_fields, clk_i, rst_ni, out_v_q && out_ovf_q, out_last_q && out_id_q == '0 && out_time_q == '0)
  `PPS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule
